FILE: hdl/rmts_pkg.sv
// Package with the shared types and constants of the rate-monotonic tick scheduler.
`timescale 1ns / 1ps

package rmts_pkg;

    localparam int MAX_TASKS_DEFAULT = 4;

    localparam int FIELD_W    = 16;
    localparam int WORD_W     = 48;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int RUN_IDX_W  = 2;
    localparam int MASK_W     = 4;

    // Number of per-task word registers on the configuration port.
    localparam int NUM_TASK_REGS = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK0_WORD = 3'd1;

    localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 3'd1;

    // Bit positions of the fields inside a task word.
    localparam int PERIOD_LSB = 0;
    localparam int BUDGET_LSB = 16;
    localparam int OFFSET_LSB = 32;

    // Best candidate seen so far, handed from cell to cell.
    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] best_period;
    } chain_t;

    // One result item.
    typedef struct packed {
        logic [RUN_IDX_W-1:0] running_task;
        logic                 idle;
        logic [MASK_W-1:0]    released_mask;
        logic [MASK_W-1:0]    overrun_mask;
        logic                 job_done;
    } result_t;

endpackage

FILE: hdl/rmts_if.sv
// Handshake channel interfaces for the tick input and the result output.
`timescale 1ns / 1ps

interface rmts_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface rmts_result_if;
    logic                             valid;
    logic                             ready;
    logic [rmts_pkg::RUN_IDX_W-1:0]   running_task;
    logic                             idle;
    logic [rmts_pkg::MASK_W-1:0]      released_mask;
    logic [rmts_pkg::MASK_W-1:0]      overrun_mask;
    logic                             job_done;

    modport source (output valid, output running_task, output idle, output released_mask,
                    output overrun_mask, output job_done, input ready);
    modport sink   (input valid, input running_task, input idle, input released_mask,
                    input overrun_mask, input job_done, output ready);
endinterface

FILE: hdl/rmts_cell.sv
// One task cell: holds a task's word, release countdown and remaining budget.
`timescale 1ns / 1ps

module rmts_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [rmts_pkg::WORD_W-1:0]     wr_data,
    input  logic                            in_use,
    input  logic                            step,
    input  logic                            grant,
    input  rmts_pkg::chain_t                chain_in,
    output rmts_pkg::chain_t                chain_out,
    output logic                            claim,
    output logic                            released,
    output logic                            overrun,
    output logic                            done
);
    import rmts_pkg::*;

    logic [WORD_W-1:0]  word_reg, word_next;
    logic [FIELD_W-1:0] countdown_reg, countdown_next;
    logic [FIELD_W-1:0] budget_reg, budget_next;

    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] budget_field;
    logic               active;
    logic               rel;
    logic [FIELD_W-1:0] budget_rel;

    assign period       = word_reg[PERIOD_LSB +: FIELD_W];
    assign budget_field = word_reg[BUDGET_LSB +: FIELD_W];
    assign active       = in_use && (period != '0);
    assign rel          = active && (countdown_reg == '0);
    assign budget_rel   = rel ? budget_field : budget_reg;

    // A ready task takes over the candidate only with a strictly shorter period,
    // so ties stay with the lower index upstream.
    assign claim     = active && (budget_rel != '0) &&
                       (!chain_in.found || (period < chain_in.best_period));
    assign chain_out = claim ? chain_t'{found: 1'b1, best_period: period} : chain_in;

    assign released = step && rel;
    assign overrun  = rel && (budget_reg != '0);
    assign done     = grant && (budget_rel == FIELD_W'(1));

    always_comb
    begin
        word_next      = word_reg;
        countdown_next = countdown_reg;
        budget_next    = budget_reg;
        if (wr_en)
        begin
            word_next      = wr_data;
            countdown_next = wr_data[OFFSET_LSB +: FIELD_W];
            budget_next    = '0;
        end
        else if (step && active)
        begin
            countdown_next = rel ? (period - FIELD_W'(1)) : (countdown_reg - FIELD_W'(1));
            budget_next    = grant ? (budget_rel - FIELD_W'(1)) : budget_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= '0;
            countdown_reg <= '0;
            budget_reg    <= '0;
        end
        else
        begin
            word_reg      <= word_next;
            countdown_reg <= countdown_next;
            budget_reg    <= budget_next;
        end
    end

endmodule

FILE: hdl/rmts_out_buf.sv
// Two-entry output buffer that decouples the result channel from the tick channel.
`timescale 1ns / 1ps

module rmts_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rmts_pkg::result_t  push_data,
    output logic               can_push,
    rmts_result_if.source      results
);
    import rmts_pkg::*;

    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    pop;

    assign pop      = out_valid_reg && results.ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (push)
        begin
            // The skid stage is empty whenever a beat is pushed.
            if (!out_valid_reg || pop)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_next        = skid_reg;
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign results.valid         = out_valid_reg;
    assign results.running_task  = out_reg.running_task;
    assign results.idle          = out_reg.idle;
    assign results.released_mask = out_reg.released_mask;
    assign results.overrun_mask  = out_reg.overrun_mask;
    assign results.job_done      = out_reg.job_done;

endmodule

FILE: hdl/rate_monotonic_tick_scheduler.sv
// Top level of the rate-monotonic tick scheduler: task cells, selection and output buffer.
// Usage: each beat on the ticks channel carries one tick bit. A beat with tick high
// advances time by one unit: tasks whose release countdown has run out get their
// budget reloaded (flagged as overrun when work was left), and the ready task with
// the shortest period runs one unit, ties going to the lower index. A beat with tick
// low leaves the state alone and yields an idle result. Every tick beat produces
// exactly one beat on the results channel, in order.
// Configuration is written through cfg_we, cfg_index and cfg_data while the block is
// idle; a task word write also restarts that task from its offset.
// Each result is registered in the output buffer. Throughput is one tick per cycle while
// the buffer has room, set by the combinational priority chain through the task cells.
// A two-entry output buffer keeps ticks flowing while a result waits; ticks.ready
// falls only when both entries are full, so a stalled receiver holds the scheduler.
// After reset task_count is one, all task words are zero (every task disabled), all
// countdowns and budgets are zero and the output buffer is empty.
`timescale 1ns / 1ps

module rate_monotonic_tick_scheduler #(
    parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rmts_pkg::WORD_W-1:0]     cfg_data,
    rmts_tick_if.sink                       ticks,
    rmts_result_if.source                   results
);
    import rmts_pkg::*;

    // Only the first four tasks have word registers and mask bits.
    localparam int WR_TASKS = (MAX_TASKS < NUM_TASK_REGS) ? MAX_TASKS : NUM_TASK_REGS;
    localparam int MASK_N   = (MAX_TASKS < MASK_W) ? MAX_TASKS : MASK_W;

    logic [COUNT_W-1:0] task_count_reg, task_count_next;

    logic                 accept;
    logic                 step;
    logic                 can_push;
    chain_t               chain [MAX_TASKS+1];
    logic [MAX_TASKS-1:0] claim;
    logic [MAX_TASKS-1:0] grant;
    logic [MAX_TASKS-1:0] released;
    logic [MAX_TASKS-1:0] overrun;
    logic [MAX_TASKS-1:0] done;
    logic [MAX_TASKS-1:0] wr_en;
    logic [MAX_TASKS-1:0] in_use;
    result_t              result;

    assign accept      = ticks.valid && ticks.ready;
    assign step        = accept && ticks.tick;
    assign ticks.ready = can_push;

    // Task count register; saturation at MAX_TASKS falls out of the per-cell compare.
    always_comb
    begin
        task_count_next = task_count_reg;
        if (cfg_we && (cfg_index == REG_TASK_COUNT))
        begin
            task_count_next = cfg_data[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= TASK_COUNT_RESET;
        end
        else
        begin
            task_count_reg <= task_count_next;
        end
    end

    assign chain[0] = '{found: 1'b0, best_period: '0};

    // The row of cells: each cell passes the best candidate so far to its right neighbor.
    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        if (k < WR_TASKS)
        begin : g_wr
            assign wr_en[k] = cfg_we && (cfg_index == (REG_TASK0_WORD + CFG_IDX_W'(k)));
        end
        else
        begin : g_no_wr
            assign wr_en[k] = 1'b0;
        end

        assign in_use[k] = (COUNT_W'(k) < task_count_reg);

        rmts_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en[k]),
            .wr_data   (cfg_data),
            .in_use    (in_use[k]),
            .step      (step),
            .grant     (grant[k]),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1]),
            .claim     (claim[k]),
            .released  (released[k]),
            .overrun   (overrun[k]),
            .done      (done[k])
        );
    end

    // The last cell to claim holds the final winner; earlier claims were displaced.
    always_comb
    begin
        logic later;
        later = 1'b0;
        grant = '0;
        for (int k = MAX_TASKS - 1; k >= 0; k--)
        begin
            grant[k] = step && claim[k] && !later;
            later    = later | claim[k];
        end
    end

    always_comb
    begin
        result               = '0;
        result.idle          = !(step && chain[MAX_TASKS].found);
        result.job_done      = |done;
        for (int k = 0; k < MAX_TASKS; k++)
        begin
            if (grant[k])
            begin
                result.running_task = RUN_IDX_W'(k);
            end
        end
        for (int k = 0; k < MASK_N; k++)
        begin
            result.released_mask[k] = released[k];
            result.overrun_mask[k]  = released[k] && overrun[k];
        end
    end

    rmts_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .can_push  (can_push),
        .results   (results)
    );

endmodule
